// ===== hdl/kct_pkg.sv =====
// Shared constants and types of the keyed counter table.
package kct_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned ENTRY_W     = KEY_W + CNT_W;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [KEY_W-1:0]        key_t;
  typedef logic signed [CNT_W-1:0] cnt_t;

  localparam idx_t LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam cnt_t CNT_MAX  = 32'sh7FFF_FFFF;
  localparam cnt_t CNT_NEG1 = -32'sd1;
  localparam cnt_t CNT_ONE  = 32'sd1;
  localparam cnt_t CNT_ZERO = 32'sd0;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_INC      = 3'd2,
    OP_DEC      = 3'd3,
    OP_OVERRIDE = 3'd4,
    OP_LOOKUP   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

// ===== hdl/kct_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module kct_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/keyed_counter_table_core.sv =====
// Top level of the keyed counter table: request scan, update and result register.
//
// Requests enter on the slave stream (s_axis_*) and each produces exactly one
// result item on the master stream (m_axis_*). An item is taken only while the
// block is idle; it then scans every entry of the key RAM, one read per cycle,
// noting the matching entry and the lowest free slot, and finally writes back
// at most one entry. The length of the scan is set by the single read port of
// the entry RAM; the next item may be accepted in the cycle after the result
// is loaded.
// The result sits in an output register, so a new request may be scanned while
// the previous result still waits; if the receiver stalls, the block holds in
// its final step until the result register is free.
// Reset clears the valid marks of all entries at once; the RAM itself is not
// cleared, as the contents of an entry are only used when its valid mark is set.
module keyed_counter_table_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // operation [2:0], key_tag [34:3], new_value [66:35], zero [71:67]
  input  logic [kct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [1:0], found [2], read_value [34:3], zero [39:35]
  output logic [kct_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import kct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  op_e  op_q;
  key_t key_q;
  cnt_t val_q;

  idx_t scan_cnt_q;
  logic issue_done_q;
  logic rd_pend_q;
  idx_t rd_idx_q;

  logic hit_q;
  idx_t slot_q;
  cnt_t cnt_val_q;
  logic free_found_q;
  idx_t free_q;

  logic [TABLE_DEPTH-1:0] valid_q;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [ENTRY_W-1:0] rd_data;
  key_t               rd_key;
  cnt_t               rd_cnt;
  logic               rd_match;

  logic    in_fire;
  logic    exec_fire;
  logic    wr_en;
  idx_t    wr_addr;
  cnt_t    wr_cnt;
  logic    set_valid;
  logic    clr_valid;
  status_e res_status;
  cnt_t    res_value;
  cnt_t    cnt_inc;
  cnt_t    cnt_dec;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  kct_ram #(
    .Width(ENTRY_W),
    .Depth(TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i({key_q, wr_cnt}),
    .raddr_i(scan_cnt_q),
    .rdata_o(rd_data)
  );

  assign rd_key   = rd_data[ENTRY_W-1:CNT_W];
  assign rd_cnt   = rd_data[CNT_W-1:0];
  assign rd_match = rd_pend_q && valid_q[rd_idx_q] && (rd_key == key_q);

  assign cnt_inc = (cnt_val_q == CNT_MAX) ? cnt_val_q : cnt_val_q + CNT_ONE;
  assign cnt_dec = (!cnt_val_q[CNT_W-1] && (cnt_val_q != CNT_ZERO)) ?
                   cnt_val_q - CNT_ONE : CNT_ZERO;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_pend_q && (rd_idx_q == LAST_IDX)) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = slot_q;
    wr_cnt     = cnt_val_q;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    res_status = ST_DONE;
    res_value  = CNT_NEG1;
    unique case (op_q)
      OP_ADD: begin
        if (hit_q) begin
          res_status = ST_PRESENT;
          res_value  = cnt_val_q;
        end else if (!free_found_q) begin
          res_status = ST_FULL;
        end else begin
          wr_en     = exec_fire;
          wr_addr   = free_q;
          wr_cnt    = val_q;
          set_valid = exec_fire;
          res_value = val_q;
        end
      end
      OP_REMOVE: begin
        if (hit_q) begin
          clr_valid = exec_fire;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_INC: begin
        if (hit_q) begin
          wr_en     = exec_fire;
          wr_cnt    = cnt_inc;
          res_value = cnt_inc;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_DEC: begin
        if (hit_q) begin
          wr_en     = exec_fire;
          wr_cnt    = cnt_dec;
          res_value = cnt_dec;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_OVERRIDE: begin
        if (hit_q) begin
          wr_en     = exec_fire;
          wr_cnt    = val_q;
          res_value = val_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit_q) begin
          res_value = cnt_val_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issue_done_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        issue_done_q <= 1'b0;
        rd_pend_q    <= 1'b0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        rd_pend_q <= !issue_done_q;
        if (scan_cnt_q == LAST_IDX) begin
          issue_done_q <= 1'b1;
        end
        if (rd_match) begin
          hit_q <= 1'b1;
        end
        if (rd_pend_q && !valid_q[rd_idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (set_valid) begin
        valid_q[wr_addr] <= 1'b1;
      end else if (clr_valid) begin
        valid_q[slot_q] <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= op_e'(s_axis_tdata[2:0]);
      key_q      <= s_axis_tdata[34:3];
      val_q      <= s_axis_tdata[66:35];
      scan_cnt_q <= '0;
    end else if ((state_q == S_SCAN) && !issue_done_q) begin
      rd_idx_q <= scan_cnt_q;
      if (scan_cnt_q != LAST_IDX) begin
        scan_cnt_q <= scan_cnt_q + idx_t'(1);
      end
    end
    if (rd_match) begin
      slot_q    <= rd_idx_q;
      cnt_val_q <= rd_cnt;
    end
    if ((state_q == S_SCAN) && rd_pend_q && !valid_q[rd_idx_q] && !free_found_q) begin
      free_q <= rd_idx_q;
    end
    if (exec_fire) begin
      out_data_q <= {5'b0, res_value, hit_q, res_status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the keyed counter table: stream stimulus and a predicting scoreboard.
module tb_top;
  import kct_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam cnt_t CNT_MIN = 32'sh8000_0000;
  localparam int RAND_ITEMS = 1500;
  localparam int KEY_POOL = 96;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 5000;

  class kct_scoreboard;
    typedef struct packed {
      status_e status;
      logic    found;
      cnt_t    value;
    } result_t;

    key_t        slot_key [TABLE_DEPTH];
    cnt_t        slot_cnt [TABLE_DEPTH];
    bit          slot_used[TABLE_DEPTH];
    result_t     pending[$];
    int unsigned errors;
    int unsigned noted;
    int unsigned checked;
    int unsigned status_seen[4];
    int unsigned inc_at_max;
    int unsigned dec_floored;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      if (errors < 50)
        $display("kct check: %s got %0h want %0h at result %0d", what, got, want, checked);
      errors++;
    endtask

    function void note_request(logic [2:0] op, key_t key, cnt_t val);
      int      hit;
      int      vacant;
      result_t r;
      hit = -1;
      vacant = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
        if (!slot_used[i] && vacant < 0) vacant = i;
      end
      r.status = ST_DONE;
      r.found  = (hit >= 0);
      r.value  = CNT_NEG1;
      if (op == OP_ADD) begin
        if (hit >= 0) begin
          r.status = ST_PRESENT;
          r.value  = slot_cnt[hit];
        end else if (vacant < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_used[vacant] = 1'b1;
          slot_key[vacant]  = key;
          slot_cnt[vacant]  = val;
          r.value = val;
        end
      end else if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        case (op)
          OP_REMOVE: slot_used[hit] = 1'b0;
          OP_INC: begin
            if (slot_cnt[hit] != CNT_MAX) slot_cnt[hit] = slot_cnt[hit] + CNT_ONE;
            else inc_at_max++;
          end
          OP_DEC: begin
            if (slot_cnt[hit] > CNT_ZERO) begin
              slot_cnt[hit] = slot_cnt[hit] - CNT_ONE;
            end else begin
              slot_cnt[hit] = CNT_ZERO;
              dec_floored++;
            end
          end
          OP_OVERRIDE: slot_cnt[hit] = val;
          default: ;
        endcase
        if (op != OP_REMOVE) r.value = slot_cnt[hit];
      end
      status_seen[r.status]++;
      noted++;
      pending.push_back(r);
    endfunction

    task check_result(logic [1:0] status, logic found, cnt_t value);
      result_t want;
      if (pending.size() == 0) begin
        report("unexpected item", {status, found, value}, 0);
      end else begin
        want = pending.pop_front();
        if (status !== want.status) report("status", status, want.status);
        if (found !== want.found) report("found", found, want.found);
        if (value !== want.value) report("read_value", value, want.value);
      end
      checked++;
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  kct_scoreboard sb = new();
  key_t          key_pool[KEY_POOL];
  int            stim_phase = 0;
  int unsigned   snd_idle_pct = 14;
  int unsigned   rcv_idle_pct = 55;
  int unsigned   hold_left = 0;
  bit            hold_done = 1'b0;
  int unsigned   quiet_cycles = 0;

  keyed_counter_table_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(input logic [2:0] op, input key_t key, input cnt_t val);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, val, key, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, key, val);
  endtask

  function automatic logic [2:0] pick_op(bit filling);
    int unsigned r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 55) return OP_ADD;
      if (r < 62) return OP_REMOVE;
      if (r < 72) return OP_INC;
      if (r < 82) return OP_DEC;
      if (r < 89) return OP_OVERRIDE;
    end else begin
      if (r < 12) return OP_ADD;
      if (r < 50) return OP_REMOVE;
      if (r < 62) return OP_INC;
      if (r < 74) return OP_DEC;
      if (r < 82) return OP_OVERRIDE;
    end
    if (r < 96) return OP_LOOKUP;
    return (r < 98) ? OP_SPARE6 : OP_SPARE7;
  endfunction

  function automatic key_t pick_key();
    if ($urandom_range(99) < 88) return key_pool[$urandom_range(KEY_POOL-1)];
    return $urandom;
  endfunction

  function automatic cnt_t pick_value();
    case ($urandom_range(13))
      0: return CNT_MAX;
      1: return CNT_MIN;
      2: return CNT_ZERO;
      3: return CNT_ONE;
      4: return CNT_NEG1;
      5: return CNT_MAX - CNT_ONE;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[34:3]);
      if (!hold_done && stim_phase == 2) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: every operation on an absent key, then the saturation and floor cases.
    send_item(OP_LOOKUP, 32'h0000_0000, CNT_ZERO);
    send_item(OP_REMOVE, 32'h0000_0000, CNT_ZERO);
    send_item(OP_INC, 32'hFFFF_FFFF, CNT_ZERO);
    send_item(OP_DEC, 32'hFFFF_FFFF, CNT_ZERO);
    send_item(OP_OVERRIDE, 32'h0000_0000, CNT_MAX);
    send_item(OP_ADD, 32'h0000_0000, CNT_MAX);
    send_item(OP_INC, 32'h0000_0000, CNT_ZERO);
    send_item(OP_ADD, 32'h0000_0000, CNT_MIN);
    send_item(OP_ADD, 32'hFFFF_FFFF, CNT_MIN);
    send_item(OP_DEC, 32'hFFFF_FFFF, CNT_ZERO);
    send_item(OP_DEC, 32'hFFFF_FFFF, CNT_NEG1);
    send_item(OP_OVERRIDE, 32'hFFFF_FFFF, CNT_ONE);
    send_item(OP_DEC, 32'hFFFF_FFFF, CNT_ZERO);
    send_item(OP_INC, 32'hFFFF_FFFF, CNT_MAX);
    send_item(OP_OVERRIDE, 32'h0000_0000, CNT_NEG1);
    send_item(OP_DEC, 32'h0000_0000, CNT_ZERO);
    send_item(OP_SPARE6, 32'h0000_0000, CNT_MAX);
    send_item(OP_SPARE7, 32'hFFFF_FFFF, CNT_MIN);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, CNT_ZERO);
    send_item(OP_REMOVE, 32'h0000_0000, CNT_ZERO);
    send_item(OP_LOOKUP, 32'h0000_0000, CNT_ZERO);
    send_item(OP_REMOVE, 32'hFFFF_FFFF, CNT_ZERO);

    // Alternate filling and draining stretches so that the table reaches full and empties again.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      stim_phase = n / (RAND_ITEMS / 3);
      case (stim_phase)
        0: begin snd_idle_pct = 14; rcv_idle_pct = 55; end
        1: begin snd_idle_pct = 55; rcv_idle_pct = 14; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      send_item(pick_op(((n / 300) % 2) == 0), pick_key(), pick_value());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run: %0d requests, %0d results; done %0d, absent %0d, present %0d, full %0d.",
             sb.noted, sb.checked, sb.status_seen[ST_DONE], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_PRESENT], sb.status_seen[ST_FULL]);
    $display("Increments held at maximum: %0d; decrements floored at zero: %0d; mismatches: %0d.",
             sb.inc_at_max, sb.dec_floored, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/kct_pkg.sv
hdl/kct_ram.sv
hdl/keyed_counter_table_core.sv
sim/tb_top.sv
